// ===== rtl/pcs_pkg.sv =====
package pcs_pkg;

    localparam int WORD_W        = 32;
    localparam int TIME_W        = 31;
    localparam int CMD_W         = 3;
    localparam int CFG_IDX_W     = 4;
    localparam int DEF_FRAC_BITS = 16;

    typedef logic signed [WORD_W-1:0]   word_t;
    typedef logic signed [2*WORD_W-1:0] dword_t;
    typedef logic [TIME_W-1:0]          tval_t;

    localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    // command codes carried by an input word
    typedef enum logic [CMD_W-1:0] {
        CMD_MEAS = 3'd0,
        CMD_SET  = 3'd1,
        CMD_TICK = 3'd2,
        CMD_EN   = 3'd3,
        CMD_DIS  = 3'd4,
        CMD_RST  = 3'd5
    } cmd_t;

    // configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP   = 4'd0,
        REG_TI   = 4'd1,
        REG_TD   = 4'd2,
        REG_DT   = 4'd3,
        REG_OMIN = 4'd4,
        REG_OMAX = 4'd5,
        REG_IMIN = 4'd6,
        REG_IMAX = 4'd7
    } reg_idx_t;

    typedef struct packed {
        word_t kp;
        tval_t ti;
        tval_t td;
        tval_t dt;
        word_t omin;
        word_t omax;
        word_t imin;
        word_t imax;
    } cfg_t;

    typedef enum logic [2:0] {
        MD_P,
        MD_KD,
        MD_NUM,
        MD_KIE,
        MD_STEP
    } mul_dst_t;

    typedef enum logic {
        DD_KI,
        DD_D
    } div_dst_t;

    typedef struct packed {
        logic     ld_meas;
        logic     ld_target;
        logic     clr_state;
        logic     diff;
        logic     mul_go;
        mul_dst_t mul_dst;
        logic     div_go;
        div_dst_t div_dst;
        logic     clr_ki;
        logic     upd_int;
        logic     sum;
        logic     emit;
    } dp_cmd_t;

    typedef struct packed {
        logic ti_zero;
        logic div_done;
        logic res_free;
    } dp_sts_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_MP,
        S_MKD,
        S_WKD,
        S_MNUM,
        S_KI,
        S_WKI,
        S_MKIE,
        S_WKIE,
        S_MSTEP,
        S_WSTEP,
        S_INT,
        S_WD,
        S_SUM,
        S_EMIT
    } st_t;

    function automatic word_t sat_word(input dword_t v);
        word_t r;
        if (v > dword_t'(WORD_MAX))
            r = WORD_MAX;
        else if (v < dword_t'(WORD_MIN))
            r = WORD_MIN;
        else
            r = v[WORD_W-1:0];
        return r;
    endfunction

endpackage

// ===== rtl/pcs_cfg.sv =====
module pcs_cfg
    import pcs_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_idx,
    input  logic [WORD_W-1:0]    wr_data,
    output cfg_t                 cfg
);

    // dt resets to 1.0
    localparam tval_t DT_ONE = tval_t'(1) << FRAC_BITS;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp   <= '0;
            cfg_reg.ti   <= '0;
            cfg_reg.td   <= '0;
            cfg_reg.dt   <= DT_ONE;
            cfg_reg.omin <= WORD_MIN;
            cfg_reg.omax <= WORD_MAX;
            cfg_reg.imin <= WORD_MIN;
            cfg_reg.imax <= WORD_MAX;
        end
        else if (wr_en)
        begin
            case (wr_idx)
                REG_KP:   cfg_reg.kp   <= $signed(wr_data);
                REG_TI:   cfg_reg.ti   <= wr_data[TIME_W-1:0];
                REG_TD:   cfg_reg.td   <= wr_data[TIME_W-1:0];
                REG_DT:   cfg_reg.dt   <= wr_data[TIME_W-1:0];
                REG_OMIN: cfg_reg.omin <= $signed(wr_data);
                REG_OMAX: cfg_reg.omax <= $signed(wr_data);
                REG_IMIN: cfg_reg.imin <= $signed(wr_data);
                REG_IMAX: cfg_reg.imax <= $signed(wr_data);
                default:  cfg_reg      <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/pcs_div.sv =====
module pcs_div
    import pcs_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [WORD_W:0] numer,
    input  tval_t               denom,
    output logic                done,
    output word_t               quot
);

    // restoring divider, one quotient bit per cycle over |numer| << FRAC_BITS
    localparam int NUM_W = WORD_W + FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  n_reg;
    logic [TIME_W-1:0] rem_reg;
    tval_t             d_reg;
    logic              neg_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;

    logic              busy;
    logic [WORD_W:0]   mag;
    logic [WORD_W-1:0] trial;
    logic [WORD_W-1:0] diff;
    logic              ge;
    dword_t            qmag;

    assign busy  = (cnt_reg != '0);
    assign mag   = numer[WORD_W] ? -numer : numer;
    assign trial = {rem_reg, n_reg[NUM_W-1]};
    assign ge    = (trial >= {1'b0, d_reg});
    assign diff  = trial - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy && (cnt_reg == CNT_W'(1));
            if (start)
                cnt_reg <= CNT_W'(NUM_W);
            else if (busy)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg   <= {mag[WORD_W-1:0], {FRAC_BITS{1'b0}}};
            rem_reg <= '0;
            d_reg   <= denom;
            neg_reg <= numer[WORD_W];
        end
        else if (busy)
        begin
            n_reg   <= {n_reg[NUM_W-2:0], ge};
            rem_reg <= ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
        end
    end

    // truncation toward zero, then saturate
    assign qmag = dword_t'({{(2*WORD_W-NUM_W){1'b0}}, n_reg});
    assign quot = sat_word(neg_reg ? -qmag : qmag);
    assign done = done_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (cnt_reg == '0))
        else $error("divider started while a division is in flight");

endmodule

// ===== rtl/pcs_dp.sv =====
module pcs_dp
    import pcs_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  dp_cmd_t ctl,
    input  cfg_t    cfg,
    input  word_t   sample,
    input  logic    res_stall,
    output dp_sts_t sts,
    output logic    res_valid,
    output word_t   drive_output,
    output word_t   error_value,
    output word_t   p_term,
    output word_t   i_term,
    output word_t   d_term
);

    function automatic word_t clamp(input word_t v, input word_t lo, input word_t hi);
        word_t t;
        t = (v < lo) ? lo : v;
        return (t > hi) ? hi : t;
    endfunction

    // controller state that survives between words
    word_t target_reg;
    word_t meas_reg;
    word_t prior_reg;
    word_t integ_reg;

    // per-tick working registers
    word_t err_reg;
    word_t delta_reg;
    word_t p_reg;
    word_t kd_reg;
    word_t num_reg;
    word_t ki_reg;
    word_t kie_reg;
    word_t step_reg;
    word_t dterm_reg;
    word_t y_reg;

    // shared multiplier stage
    dword_t   prod_reg;
    dword_t   prod_next;
    logic     mul_vld_reg;
    mul_dst_t mul_dst_reg;
    word_t    mul_a;
    word_t    mul_b;
    word_t    mul_res;

    div_dst_t div_dst_reg;
    logic signed [WORD_W:0] div_numer;
    tval_t    div_denom;
    logic     div_done;
    word_t    div_quot;

    // output register
    logic  res_vld_reg;
    word_t out_y_reg;
    word_t out_err_reg;
    word_t out_p_reg;
    word_t out_i_reg;
    word_t out_d_reg;

    tval_t dt_eff;
    logic signed [WORD_W:0]   err_wide;
    logic signed [WORD_W:0]   delta_wide;
    logic signed [WORD_W:0]   integ_wide;
    logic signed [WORD_W+1:0] total_wide;
    word_t integ_next;
    word_t y_next;

    assign dt_eff = (cfg.dt == '0) ? tval_t'(1) : cfg.dt;

    assign err_wide   = {target_reg[WORD_W-1], target_reg} - {meas_reg[WORD_W-1], meas_reg};
    assign delta_wide = {meas_reg[WORD_W-1], meas_reg} - {prior_reg[WORD_W-1], prior_reg};
    assign integ_wide = {integ_reg[WORD_W-1], integ_reg} + {step_reg[WORD_W-1], step_reg};
    assign total_wide = {{2{p_reg[WORD_W-1]}}, p_reg}
                      + {{2{integ_reg[WORD_W-1]}}, integ_reg}
                      + {{2{dterm_reg[WORD_W-1]}}, dterm_reg};

    assign integ_next = clamp(sat_word(dword_t'(integ_wide)), cfg.imin, cfg.imax);
    assign y_next     = clamp(sat_word(dword_t'(total_wide)), cfg.omin, cfg.omax);

    // multiplier operand select
    always_comb
    begin
        case (ctl.mul_dst)
            MD_P:
            begin
                mul_a = cfg.kp;
                mul_b = err_reg;
            end
            MD_KD:
            begin
                mul_a = cfg.kp;
                mul_b = $signed({1'b0, cfg.td});
            end
            MD_NUM:
            begin
                mul_a = kd_reg;
                mul_b = delta_reg;
            end
            MD_KIE:
            begin
                mul_a = ki_reg;
                mul_b = err_reg;
            end
            MD_STEP:
            begin
                mul_a = kie_reg;
                mul_b = $signed({1'b0, dt_eff});
            end
            default:
            begin
                mul_a = cfg.kp;
                mul_b = err_reg;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;
    // arithmetic shift floors the exact product
    assign mul_res   = sat_word(prod_reg >>> FRAC_BITS);

    // Ki = (Kp << F) / Ti, D = (-num << F) / dt
    assign div_numer = (ctl.div_dst == DD_KI) ? {cfg.kp[WORD_W-1], cfg.kp}
                                              : ~{num_reg[WORD_W-1], num_reg} + 1'b1;
    assign div_denom = (ctl.div_dst == DD_KI) ? cfg.ti : dt_eff;

    pcs_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.div_go),
        .numer (div_numer),
        .denom (div_denom),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
            meas_reg   <= '0;
            prior_reg  <= '0;
            integ_reg  <= '0;
        end
        else if (ctl.clr_state)
        begin
            target_reg <= '0;
            meas_reg   <= '0;
            prior_reg  <= '0;
            integ_reg  <= '0;
        end
        else
        begin
            if (ctl.ld_meas)
                meas_reg <= sample;
            if (ctl.ld_target)
                target_reg <= sample;
            if (ctl.diff)
                prior_reg <= meas_reg;
            if (ctl.upd_int)
                integ_reg <= integ_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_vld_reg <= 1'b0;
            mul_dst_reg <= MD_P;
            div_dst_reg <= DD_KI;
        end
        else
        begin
            mul_vld_reg <= ctl.mul_go;
            if (ctl.mul_go)
                mul_dst_reg <= ctl.mul_dst;
            if (ctl.div_go)
                div_dst_reg <= ctl.div_dst;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul_go)
            prod_reg <= prod_next;
        if (ctl.diff)
        begin
            err_reg   <= sat_word(dword_t'(err_wide));
            delta_reg <= sat_word(dword_t'(delta_wide));
        end
        if (mul_vld_reg)
        begin
            case (mul_dst_reg)
                MD_P:    p_reg    <= mul_res;
                MD_KD:   kd_reg   <= mul_res;
                MD_NUM:  num_reg  <= mul_res;
                MD_KIE:  kie_reg  <= mul_res;
                MD_STEP: step_reg <= mul_res;
                default: p_reg    <= mul_res;
            endcase
        end
        if (ctl.clr_ki)
            ki_reg <= '0;
        else if (div_done && div_dst_reg == DD_KI)
            ki_reg <= div_quot;
        if (div_done && div_dst_reg == DD_D)
            dterm_reg <= div_quot;
        if (ctl.sum)
            y_reg <= y_next;
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_vld_reg <= 1'b0;
        else if (ctl.emit)
            res_vld_reg <= 1'b1;
        else if (!res_stall)
            res_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            out_y_reg   <= y_reg;
            out_err_reg <= err_reg;
            out_p_reg   <= p_reg;
            out_i_reg   <= integ_reg;
            out_d_reg   <= dterm_reg;
        end
    end

    assign sts.ti_zero  = (cfg.ti == '0);
    assign sts.div_done = div_done;
    assign sts.res_free = !res_vld_reg || !res_stall;

    assign res_valid    = res_vld_reg;
    assign drive_output = out_y_reg;
    assign error_value  = out_err_reg;
    assign p_term       = out_p_reg;
    assign i_term       = out_i_reg;
    assign d_term       = out_d_reg;

endmodule

// ===== rtl/pcs_ctrl.sv =====
module pcs_ctrl
    import pcs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    input  logic [CMD_W-1:0] cmd_code,
    output logic             cmd_stall,
    input  dp_sts_t          sts,
    output dp_cmd_t          ctl
);

    st_t  state_reg;
    st_t  state_next;
    logic run_reg;
    logic run_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            run_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            run_reg   <= run_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        run_next   = run_reg;
        ctl        = '0;
        cmd_stall  = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                cmd_stall = 1'b0;
                if (cmd_valid)
                begin
                    case (cmd_code)
                        CMD_MEAS: ctl.ld_meas   = 1'b1;
                        CMD_SET:  ctl.ld_target = 1'b1;
                        CMD_TICK:
                        begin
                            if (run_reg)
                                state_next = S_DIFF;
                        end
                        CMD_EN:   run_next = 1'b1;
                        CMD_DIS:  run_next = 1'b0;
                        CMD_RST:
                        begin
                            ctl.clr_state = 1'b1;
                            run_next      = 1'b0;
                        end
                        default:  run_next = run_reg;
                    endcase
                end
            end
            S_DIFF:
            begin
                ctl.diff   = 1'b1;
                state_next = S_MP;
            end
            S_MP:
            begin
                ctl.mul_go  = 1'b1;
                ctl.mul_dst = MD_P;
                state_next  = S_MKD;
            end
            S_MKD:
            begin
                ctl.mul_go  = 1'b1;
                ctl.mul_dst = MD_KD;
                state_next  = S_WKD;
            end
            S_WKD:
                state_next = S_MNUM;
            S_MNUM:
            begin
                ctl.mul_go  = 1'b1;
                ctl.mul_dst = MD_NUM;
                state_next  = S_KI;
            end
            S_KI:
            begin
                // zero Ti switches the integral path off
                if (sts.ti_zero)
                begin
                    ctl.clr_ki = 1'b1;
                    state_next = S_MKIE;
                end
                else
                begin
                    ctl.div_go  = 1'b1;
                    ctl.div_dst = DD_KI;
                    state_next  = S_WKI;
                end
            end
            S_WKI:
            begin
                if (sts.div_done)
                    state_next = S_MKIE;
            end
            S_MKIE:
            begin
                ctl.mul_go  = 1'b1;
                ctl.mul_dst = MD_KIE;
                state_next  = S_WKIE;
            end
            S_WKIE:
                state_next = S_MSTEP;
            S_MSTEP:
            begin
                ctl.mul_go  = 1'b1;
                ctl.mul_dst = MD_STEP;
                state_next  = S_WSTEP;
            end
            S_WSTEP:
                state_next = S_INT;
            S_INT:
            begin
                ctl.upd_int = 1'b1;
                ctl.div_go  = 1'b1;
                ctl.div_dst = DD_D;
                state_next  = S_WD;
            end
            S_WD:
            begin
                if (sts.div_done)
                    state_next = S_SUM;
            end
            S_SUM:
            begin
                ctl.sum    = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.res_free)
                begin
                    ctl.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    a_tick_off: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && cmd_valid && cmd_code == CMD_TICK && !run_reg)
            |=> (state_reg == S_IDLE))
        else $error("tick while disabled started a control cycle");

    a_rst_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && cmd_valid && cmd_code == CMD_RST) |=> !run_reg)
        else $error("reset command left the loop enabled");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> (state_reg == S_WKI || state_reg == S_WD))
        else $error("division finished outside a wait state");

endmodule

// ===== rtl/pid_control_step_core.sv =====
// PID controller, derivative on measurement, integral anti-windup, signed fixed point.
//
// Command channel (cmd_valid / cmd_stall): each word carries cmd and sample_value.
//   measurement, setpoint, enable, disable and reset are handled while idle and give no
//   result. A tick while enabled runs the full control update and produces one result
//   word; a tick while disabled is dropped.
// Result channel (res_valid / res_stall): drive_output plus error, P, I, D telemetry.
//   The result sits in an output register, so new commands are taken while it waits.
//   If the receiver stalls and another tick finishes, the core holds in its last step
//   (cmd_stall high) until the register frees up.
// Config channel (cfg_valid / cfg_ready): always ready; write only while idle.
// Tick schedule: commands stall from tick acceptance until the result is loaded.
//   Two serial divisions of 32 + FRAC_BITS steps each dominate (Kp/Ti, skipped
//   when Ti = 0, then the derivative over dt); the five multiplies share one
//   32x32 multiplier.
// Reset: config registers return to their defaults (dt = 1.0, clamps wide open),
//   setpoint, measurement, integral and previous measurement clear, loop disabled.
module pid_control_step_core
    import pcs_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,

    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  logic [CMD_W-1:0]     cmd,
    input  word_t                sample_value,

    output logic                 res_valid,
    input  logic                 res_stall,
    output word_t                drive_output,
    output word_t                error_value,
    output word_t                p_term,
    output word_t                i_term,
    output word_t                d_term
);

    cfg_t    cfg;
    dp_cmd_t ctl;
    dp_sts_t sts;

    // register file takes writes every cycle
    assign cfg_ready = 1'b1;

    pcs_cfg #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cfg_valid),
        .wr_idx  (cfg_index),
        .wr_data (cfg_data),
        .cfg     (cfg)
    );

    // sequencer: decodes commands, steps the tick schedule
    pcs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_code  (cmd),
        .cmd_stall (cmd_stall),
        .sts       (sts),
        .ctl       (ctl)
    );

    // datapath: state, shared multiplier, serial divider, output register
    pcs_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .cfg          (cfg),
        .sample       (sample_value),
        .res_stall    (res_stall),
        .sts          (sts),
        .res_valid    (res_valid),
        .drive_output (drive_output),
        .error_value  (error_value),
        .p_term       (p_term),
        .i_term       (i_term),
        .d_term       (d_term)
    );

endmodule

// ===== tb/pid_control_step_core_tb.sv =====
module pid_control_step_core_tb
    import pcs_pkg::*;
();

    // Q16.16 throughout; the core is built with the default fraction width.
    localparam int FRAC            = DEF_FRAC_BITS;
    localparam int ONE             = 1 << FRAC;
    localparam int NUM_REGS        = 8;
    localparam int NUM_PHASES      = 9;     // phase 0 is the directed one
    localparam int ITEMS_PER_PHASE = 69;    // ~550 random words over 8 phases
    localparam int MAX_WAIT        = 17;
    // A tick inside the core fits in this with margin.
    localparam int DRAIN_CYCLES    = 160;
    // Longest legal quiet stretch is a drain pause or a tick plus both idles.
    localparam int WATCHDOG_LIMIT  = 2000;

    // One telemetry word as the core presents it.
    typedef struct packed {
        word_t drive;
        word_t err;
        word_t p;
        word_t i;
        word_t d;
    } pid_result_t;

    // Shadow copy of the controller: registers, loop state, and the telemetry
    // words still owed by the core.
    class pid_shadow;
        longint kp, ti, td, dt_reg, omin, omax, imin, imax;
        longint target, meas, integ, prior;
        bit enabled;
        pid_result_t due_outputs[$];
        int errors;

        function new();
            errors = 0;
            kp     = 0;
            ti     = 0;
            td     = 0;
            dt_reg = longint'(ONE);
            omin   = longint'(WORD_MIN);
            omax   = longint'(WORD_MAX);
            imin   = longint'(WORD_MIN);
            imax   = longint'(WORD_MAX);
            clear_loop();
        endfunction

        function void clear_loop();
            target  = 0;
            meas    = 0;
            integ   = 0;
            prior   = 0;
            enabled = 1'b0;
        endfunction

        static function longint sat32(longint v);
            if (v > longint'(WORD_MAX))
                return longint'(WORD_MAX);
            if (v < longint'(WORD_MIN))
                return longint'(WORD_MIN);
            return v;
        endfunction

        // exact product, floor shift, saturate
        static function longint qmul(longint a, longint b);
            return sat32((a * b) >>> FRAC);
        endfunction

        // scaled dividend, truncate toward zero, saturate
        static function longint qdiv(longint a, longint b);
            return sat32((a <<< FRAC) / b);
        endfunction

        // max wins when the limits are crossed
        static function longint clamp(longint v, longint lo, longint hi);
            longint t;
            t = (v < lo) ? lo : v;
            return (t > hi) ? hi : t;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
            case (idx)
                REG_KP:   kp     = longint'($signed(data));
                REG_TI:   ti     = longint'(data[TIME_W-1:0]);
                REG_TD:   td     = longint'(data[TIME_W-1:0]);
                REG_DT:   dt_reg = longint'(data[TIME_W-1:0]);
                REG_OMIN: omin   = longint'($signed(data));
                REG_OMAX: omax   = longint'($signed(data));
                REG_IMIN: imin   = longint'($signed(data));
                REG_IMAX: imax   = longint'($signed(data));
                default:  ;
            endcase
        endfunction

        function pid_result_t control_update();
            longint step_dt, e, pv, ki, stp, kd, dm, num, dv, y;
            pid_result_t r;
            step_dt = (dt_reg == 0) ? 1 : dt_reg;
            e  = sat32(target - meas);
            pv = qmul(kp, e);
            ki = (ti == 0) ? 0 : qdiv(kp, ti);
            stp   = qmul(qmul(ki, e), step_dt);
            integ = clamp(sat32(integ + stp), imin, imax);
            kd = qmul(kp, td);
            dm = sat32(meas - prior);
            num = qmul(kd, dm);
            dv = qdiv(-num, step_dt);
            prior = meas;
            y = clamp(sat32(pv + integ + dv), omin, omax);
            r.drive = y[WORD_W-1:0];
            r.err   = e[WORD_W-1:0];
            r.p     = pv[WORD_W-1:0];
            r.i     = integ[WORD_W-1:0];
            r.d     = dv[WORD_W-1:0];
            return r;
        endfunction

        function void note_cmd(logic [CMD_W-1:0] c, word_t v);
            case (c)
                CMD_MEAS: meas    = longint'(v);
                CMD_SET:  target  = longint'(v);
                CMD_EN:   enabled = 1'b1;
                CMD_DIS:  enabled = 1'b0;
                CMD_RST:  clear_loop();
                CMD_TICK: if (enabled) due_outputs.push_back(control_update());
                default:  ;
            endcase
        endfunction

        function void compare_field(string name, word_t want, word_t seen);
            if (want !== seen)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
                errors++;
            end
        endfunction

        function void check_result(pid_result_t got);
            pid_result_t want;
            if (due_outputs.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none, actual drive %0d",
                         $time, got.drive);
                errors++;
                return;
            end
            want = due_outputs.pop_front();
            compare_field("drive_output", want.drive, got.drive);
            compare_field("error_value", want.err, got.err);
            compare_field("p_term", want.p, got.p);
            compare_field("i_term", want.i, got.i);
            compare_field("d_term", want.d, got.d);
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0]    cfg_data;
    logic                 cmd_valid;
    logic                 cmd_stall;
    logic [CMD_W-1:0]     cmd;
    word_t                sample_value;
    logic                 res_valid;
    logic                 res_stall;
    word_t                drive_output;
    word_t                error_value;
    word_t                p_term;
    word_t                i_term;
    word_t                d_term;

    pid_shadow book = new();
    bit        no_idle = 1'b0;     // when set, neither side inserts idle cycles
    int        useful_items = 0;   // words that the core acts on
    int        idle_cycles = 0;

    pid_control_step_core #(
        .FRAC_BITS(FRAC)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd(cmd),
        .sample_value(sample_value),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .drive_output(drive_output),
        .error_value(error_value),
        .p_term(p_term),
        .i_term(i_term),
        .d_term(d_term)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Idle cycles a side waits before its next word.
    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // Uniform in [-span, span].
    function automatic int spread(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Sample values: mostly moderate, with rails, tiny values and full-range noise.
    function automatic word_t draw_value();
        word_t r;
        case ($urandom_range(0, 9))
            0:       r = WORD_MAX;
            1:       r = WORD_MIN;
            2:       r = word_t'($urandom_range(0, 2)) - 1;
            3, 4:    r = word_t'($urandom());
            default: r = word_t'(spread(16 * ONE));
        endcase
        return r;
    endfunction

    // Time registers are 31 bits wide; bit 31 of the bus must be dropped.
    function automatic logic [WORD_W-1:0] with_junk_top(logic [TIME_W-1:0] v);
        logic top;
        top = 1'($urandom_range(0, 1));
        return {top, v};
    endfunction

    // Config writes: one word per call, valid drops for a cycle after each.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        book.set_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Present one command word after a random gap. Valid is left high on accept
    // so a back-to-back word never lowers and raises it in the same step.
    task automatic push_cmd(logic [CMD_W-1:0] c, word_t v);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid    <= 1'b1;
        cmd          <= c;
        sample_value <= v;
        do @(posedge clk); while (cmd_stall !== 1'b0);
        if (c <= CMD_RST && !(c == CMD_TICK && !book.enabled))
            useful_items++;
        book.note_cmd(c, v);
    endtask

    // Wait for every owed result, then let the core finish whatever it is on.
    task automatic drain();
        cmd_valid <= 1'b0;
        while (book.due_outputs.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register settings per phase:
    //   0 hand-picked gains and clamps for the directed words
    //   1 everything at the top, both clamps crossed (max must win)
    //   2 most negative gain, Ti = 1 lsb, no derivative, zero dt (taken as 1 lsb)
    //   3 integral off (Ti = 0)
    //   others random, mostly moderate
    task automatic apply_setting(int p);
        logic [WORD_W-1:0]    kp_v, omin_v, omax_v, imin_v, imax_v;
        logic [TIME_W-1:0]    ti_v, td_v, dt_v;
        logic [CFG_IDX_W-1:0] stray_idx;
        int lo, hi, t;
        kp_v = spread(8 * ONE);
        ti_v = TIME_W'(($urandom_range(0, 7) == 0) ? $urandom()
                                                   : $urandom_range(1, 8 * ONE));
        td_v = TIME_W'(($urandom_range(0, 7) == 0) ? $urandom()
                                                   : $urandom_range(0, 4 * ONE));
        dt_v = TIME_W'(($urandom_range(0, 7) == 0) ? $urandom()
                                                   : $urandom_range(ONE / 100, 2 * ONE));
        if ($urandom_range(0, 5) == 0)
        begin
            omin_v = WORD_MIN;
            omax_v = WORD_MAX;
        end
        else
        begin
            lo = spread(128 * ONE);
            hi = lo + $urandom_range(0, 256 * ONE);
            if ($urandom_range(0, 7) == 0)
            begin
                t  = lo;
                lo = hi;
                hi = t;
            end
            omin_v = lo;
            omax_v = hi;
        end
        lo = spread(64 * ONE);
        hi = lo + $urandom_range(0, 128 * ONE);
        imin_v = lo;
        imax_v = hi;
        case (p)
            0:
            begin
                kp_v   = ONE;
                ti_v   = TIME_W'(2 * ONE);
                td_v   = TIME_W'(ONE / 2);
                dt_v   = TIME_W'(ONE);
                omin_v = -100 * ONE;
                omax_v = 100 * ONE;
                imin_v = -50 * ONE;
                imax_v = 50 * ONE;
            end
            1:
            begin
                kp_v   = WORD_MAX;
                ti_v   = {TIME_W{1'b1}};
                td_v   = {TIME_W{1'b1}};
                dt_v   = {TIME_W{1'b1}};
                omin_v = WORD_MAX;
                omax_v = WORD_MIN;
                imin_v = WORD_MAX;
                imax_v = WORD_MIN;
            end
            2:
            begin
                kp_v   = WORD_MIN;
                ti_v   = TIME_W'(1);
                td_v   = '0;
                dt_v   = '0;
                omin_v = WORD_MIN;
                omax_v = WORD_MAX;
                imin_v = WORD_MIN;
                imax_v = WORD_MAX;
            end
            3:       ti_v = '0;
            default: ;
        endcase
        write_reg(REG_KP, kp_v);
        write_reg(REG_TI, with_junk_top(ti_v));
        write_reg(REG_TD, with_junk_top(td_v));
        write_reg(REG_DT, with_junk_top(dt_v));
        write_reg(REG_OMIN, omin_v);
        write_reg(REG_OMAX, omax_v);
        write_reg(REG_IMIN, imin_v);
        write_reg(REG_IMAX, imax_v);
        // an unmapped index must leave every register alone
        stray_idx = CFG_IDX_W'(NUM_REGS + $urandom_range(0, NUM_REGS - 1));
        write_reg(stray_idx, $urandom());
    endtask

    // Result side: stall for a drawn number of cycles, then take the next word.
    // Stall is decided once per edge from the values sampled at that edge.
    initial
    begin : result_sink
        int hold;
        pid_result_t got;
        res_stall = 1'b0;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (res_valid === 1'b1 && res_stall === 1'b0)
            begin
                got = {drive_output, error_value, p_term, i_term, d_term};
                book.check_result(got);
                hold = draw_wait();
            end
            else if (hold > 0)
            begin
                hold--;
            end
            res_stall <= (hold > 0);
        end
    end

    // Watchdog: any accepted word on any channel restarts the count.
    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d results still owed",
                     $time, book.due_outputs.size());
            $display("pid_control_step_core_tb: FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : stimulus
        int p, start, roll;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        cmd_valid    = 1'b0;
        cmd          = '0;
        sample_value = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words: rails on both samples, every command, disabled tick,
        // unused codes, and a loop reset that must keep the registers.
        apply_setting(0);
        push_cmd(CMD_EN, '0);
        push_cmd(CMD_SET, 3 * ONE);
        push_cmd(CMD_MEAS, ONE);
        push_cmd(CMD_TICK, '0);
        push_cmd(CMD_MEAS, WORD_MAX);          // huge measurement step
        push_cmd(CMD_TICK, WORD_MIN);
        push_cmd(CMD_SET, WORD_MIN);           // error saturates low
        push_cmd(CMD_TICK, '0);
        push_cmd(CMD_MEAS, WORD_MIN);
        push_cmd(CMD_SET, WORD_MAX);           // error saturates high
        push_cmd(CMD_TICK, '0);
        push_cmd(CMD_TICK, '0);                // same measurement, no derivative kick
        push_cmd(CMD_DIS, '0);
        push_cmd(CMD_TICK, '0);                // ignored while disabled
        push_cmd(3'd6, WORD_MAX);              // unused codes are dropped
        push_cmd(3'd7, WORD_MIN);
        push_cmd(CMD_EN, '0);
        push_cmd(CMD_TICK, '0);
        push_cmd(CMD_RST, '0);                 // clears loop state, also disables
        push_cmd(CMD_TICK, '0);
        push_cmd(CMD_EN, '0);
        push_cmd(CMD_TICK, '0);                // everything back at zero
        push_cmd(CMD_MEAS, -1);
        push_cmd(CMD_SET, 1);
        push_cmd(CMD_TICK, '0);
        drain();

        for (p = 1; p < NUM_PHASES; p++)
        begin
            no_idle = (p % 3 == 2);
            apply_setting(p);
            start = useful_items;
            while (useful_items - start < ITEMS_PER_PHASE)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 72)
                begin
                    // regular control cycle: new measurement, maybe a new target, tick
                    if (!book.enabled)
                        push_cmd(CMD_EN, draw_value());
                    push_cmd(CMD_MEAS, draw_value());
                    if ($urandom_range(0, 2) == 0)
                        push_cmd(CMD_SET, draw_value());
                    push_cmd(CMD_TICK, draw_value());
                end
                else if (roll < 80)
                begin
                    // back-to-back ticks on a held measurement
                    push_cmd(CMD_TICK, draw_value());
                    push_cmd(CMD_TICK, draw_value());
                end
                else
                begin
                    // noise: any code, any value
                    push_cmd(CMD_W'($urandom_range(0, 7)), word_t'($urandom()));
                end
            end
            drain();
        end

        if (book.errors == 0 && book.due_outputs.size() == 0)
            $display("pid_control_step_core_tb: PASS");
        else
            $display("pid_control_step_core_tb: FAIL");
        $finish;
    end

endmodule
